// ===== hw/rtl/lzss_pkg.sv =====
// Shared types and constants for the LZSS window decoder.
// Holds the controller state enum and the command and status structs.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package lzss_pkg;

  // Width of one decoded byte
  localparam int BYTE_W = 8;

  // Token kinds carried on s_tuser
  localparam logic OP_LITERAL = 1'b0;
  localparam logic OP_MATCH   = 1'b1;

  // Match position that ends the stream
  localparam int END_MARK = 0;

  // Write pointer value at reset and after an end marker
  localparam int WP_START = 1;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_lit;    // capture literal byte as a pending result
    logic load_match;  // capture match source and length
    logic end_stream;  // return write pointer to its start value
    logic issue;       // read one window byte of the running copy
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_valid;     // a byte waits in the read stage
    logic take;        // that byte moves to the output register this cycle
    logic cnt_one;     // the next read is the last one of the copy
    logic pos_zero;    // the offered token carries the end marker position
  } dp_status_t;

endpackage : lzss_pkg

`default_nettype wire

// ===== hw/rtl/lzss_window_decoder_core.sv =====
// LZSS window decoder: a literal token gives one byte, a match of N bytes
// (N = length_code + 2) gives N bytes copied from the history window.
// A literal passes the read stage and the output register to m_tdata; a
// match token gives one byte per cycle while the output is not stalled,
// through the single read port of the window memory; an end marker gives no byte.
// Reset clears control state and sets the write pointer to 1; the window
// itself is not cleared.
`default_nettype none

module lzss_window_decoder_core
  import lzss_pkg::*;
#(
  parameter int INDEX_BITS  = 12,
  parameter int LENGTH_BITS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // literal[7:0], position, length_code, zero fill to whole bytes
  input  wire logic [((BYTE_W + INDEX_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // operation
  input  wire logic              s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // out_byte
  output logic [BYTE_W-1:0]      m_tdata,
  output logic                   m_tlast
);

  localparam int POS_LO = BYTE_W;
  localparam int LEN_LO = BYTE_W + INDEX_BITS;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Unpack token fields
  logic [BYTE_W-1:0]      literal;
  logic [INDEX_BITS-1:0]  position;
  logic [LENGTH_BITS-1:0] length_code;

  assign literal     = s_tdata[BYTE_W-1:0];
  assign position    = s_tdata[POS_LO +: INDEX_BITS];
  assign length_code = s_tdata[LEN_LO +: LENGTH_BITS];

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  lzss_dpath #(
    .INDEX_BITS  (INDEX_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .literal     (literal),
    .position    (position),
    .length_code (length_code),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .out_byte    (m_tdata),
    .out_last    (m_tlast)
  );

endmodule : lzss_window_decoder_core

`default_nettype wire

// ===== hw/rtl/lzss_ctrl.sv =====
// Controller state machine of the LZSS window decoder.
// Sequences token intake and the window copy, one byte per cycle unless the output stalls.
// Depends on lzss_pkg.
`default_nettype none

module lzss_ctrl
  import lzss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic       op,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    accept     = 1'b0;
    case (state)
      ST_IDLE: begin
        // take a token only once the previous byte left the read stage
        s_tready = !status.q_valid;
        accept   = s_tvalid && !status.q_valid;
        if (accept) begin
          if (op == OP_LITERAL) begin
            cmd.load_lit = 1'b1;
          end else if (status.pos_zero) begin
            cmd.end_stream = 1'b1;
          end else begin
            cmd.load_match = 1'b1;
            state_next     = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        // read the next byte when the read stage is empty or drains now
        cmd.issue = !status.q_valid || status.take;
        if (cmd.issue && status.cnt_one) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : lzss_ctrl

`default_nettype wire

// ===== hw/rtl/lzss_dpath.sv =====
// Datapath of the LZSS window decoder: history window memory, copy
// source and count, write pointer, read stage and output register.
// Depends on lzss_pkg; driven by lzss_ctrl through dp_cmd_t.
`default_nettype none

module lzss_dpath
  import lzss_pkg::*;
#(
  parameter int INDEX_BITS  = 12,
  parameter int LENGTH_BITS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [BYTE_W-1:0]      literal,
  input  wire logic [INDEX_BITS-1:0]  position,
  input  wire logic [LENGTH_BITS-1:0] length_code,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [BYTE_W-1:0]           out_byte,
  output logic                        out_last
);

  localparam int WIN_DEPTH = 1 << INDEX_BITS;
  localparam int MIN_MATCH = (1 + INDEX_BITS + LENGTH_BITS) / 9;
  localparam int CNT_W     = LENGTH_BITS + 1;

  logic [BYTE_W-1:0]     window [WIN_DEPTH];
  logic [BYTE_W-1:0]     mem_q;
  logic [INDEX_BITS-1:0] src;
  logic [INDEX_BITS-1:0] wp;
  logic [CNT_W-1:0]      count;
  logic                  q_valid;
  logic                  q_last;
  logic                  byp;
  logic [BYTE_W-1:0]     byp_data;
  logic [BYTE_W-1:0]     q_byte;
  logic                  out_free;
  logic                  take;

  // Byte in the read stage: forwarded write or memory read data
  assign q_byte   = byp ? byp_data : mem_q;
  assign out_free = !m_tvalid || m_tready;
  assign take     = q_valid && out_free;

  assign status.q_valid  = q_valid;
  assign status.take     = take;
  assign status.cnt_one  = (count == CNT_W'(1));
  assign status.pos_zero = (position == INDEX_BITS'(END_MARK));

  // History window: write each delivered byte, read the copy source
  always_ff @(posedge clk) begin
    if (take) begin
      window[wp] <= q_byte;
    end
    if (cmd.issue) begin
      mem_q <= window[src];
    end
  end

  // Copy source, count and forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (cmd.load_match) begin
      src   <= position;
      count <= CNT_W'(length_code) + CNT_W'(MIN_MATCH + 1);
    end else if (cmd.issue) begin
      src   <= src + INDEX_BITS'(1);
      count <= count - CNT_W'(1);
    end
    if (cmd.load_lit) begin
      byp      <= 1'b1;
      byp_data <= literal;
      q_last   <= 1'b1;
    end else if (cmd.issue) begin
      byp      <= take && (wp == src);
      byp_data <= q_byte;
      q_last   <= (count == CNT_W'(1));
    end
  end

  // Read stage occupancy and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      wp      <= INDEX_BITS'(WP_START);
    end else begin
      if (cmd.load_lit || cmd.issue) begin
        q_valid <= 1'b1;
      end else if (take) begin
        q_valid <= 1'b0;
      end
      if (cmd.end_stream) begin
        wp <= INDEX_BITS'(WP_START);
      end else if (take) begin
        wp <= wp + INDEX_BITS'(1);
      end
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= q_byte;
      out_last <= q_last;
    end
  end

endmodule : lzss_dpath

`default_nettype wire

// ===== hw/rtl/lzss_checker.sv =====
// Port-level checks for the LZSS window decoder top level.
// Bound to lzss_window_decoder_core; depends on lzss_pkg.
`default_nettype none

module lzss_checker
  import lzss_pkg::*;
#(
  parameter int INDEX_BITS  = 12,
  parameter int LENGTH_BITS = 4
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic [((BYTE_W + INDEX_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input wire logic              s_tuser,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [BYTE_W-1:0] m_tdata,
  input wire logic              m_tlast
);

  logic s_xfer;
  logic pos_end;

  assign s_xfer  = s_tvalid && s_tready;
  assign pos_end = (s_tdata[BYTE_W +: INDEX_BITS] == INDEX_BITS'(END_MARK));

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // A token that produces bytes blocks intake in the next cycle
  a_busy_after_token: assert property (@(posedge clk) disable iff (rst)
    s_xfer && (s_tuser == OP_LITERAL || !pos_end) |=> !s_tready)
    else $error("token taken while previous token still decoding");

  // A literal into an empty output passes the read stage and the output register and appears as a last byte
  a_literal_out: assert property (@(posedge clk) disable iff (rst)
    s_xfer && s_tuser == OP_LITERAL && !m_tvalid |-> ##2
      (m_tvalid && m_tlast && m_tdata == $past(s_tdata[BYTE_W-1:0], 2)))
    else $error("literal byte not delivered");

endmodule : lzss_checker

bind lzss_window_decoder_core lzss_checker #(
  .INDEX_BITS  (INDEX_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_lzss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
